@@ rtl/ids_pkg.sv @@
package ids_pkg;

	localparam int OPCODE_W = 4;
	localparam int POS_W = 7;
	localparam int ITEM_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 7;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W_DEF = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INS_FRONT = 4'd0,
		OP_INS_BACK  = 4'd1,
		OP_RD_FRONT  = 4'd2,
		OP_RD_BACK   = 4'd3,
		OP_REM_FRONT = 4'd4,
		OP_REM_BACK  = 4'd5,
		OP_RD_POS    = 4'd6,
		OP_INS_POS   = 4'd7,
		OP_REM_POS   = 4'd8
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Decoded operation that goes out to every cell; flags are already
	// qualified by a good status.
	typedef struct packed {
		logic    ins;
		logic    rem;
		logic    rd;
		status_t status;
	} op_ctl_t;

endpackage

@@ rtl/ids_cell.sv @@
module ids_cell #(
	parameter int DATA_WIDTH = ids_pkg::DATA_W_DEF,
	parameter int IDX_W = 6,
	parameter int CELL_IDX = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  ids_pkg::op_ctl_t      ctl,
	input  logic [IDX_W-1:0]      idx,
	input  logic [DATA_WIDTH-1:0] new_item,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] tap
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] tap_q;
	logic                  hit;
	logic                  above;

	assign hit   = (idx == IDX_W'(CELL_IDX));
	assign above = (idx < IDX_W'(CELL_IDX));

	// Insertion moves everything above the target one cell up; removal
	// pulls the target and everything above it one cell down.
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl.ins) begin
				if (above) begin
					data_q <= left;
				end else if (hit) begin
					data_q <= new_item;
				end
			end else if (ctl.rem) begin
				if (above || hit) begin
					data_q <= right;
				end
			end
			tap_q <= (ctl.rd && hit) ? data_q : '0;
		end
	end

	assign data = data_q;
	assign tap  = tap_q;

endmodule

@@ rtl/ids_ctrl.sv @@
module ids_ctrl #(
	parameter int DEPTH = ids_pkg::DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [ids_pkg::OPCODE_W-1:0] opcode,
	input  logic [ids_pkg::POS_W-1:0]    position,
	output ids_pkg::op_ctl_t             ctl,
	output logic [IDX_W-1:0]             idx,
	output logic [CNT_W-1:0]             count_next
);

	localparam int CMP_W = (CNT_W > ids_pkg::POS_W) ? CNT_W : ids_pkg::POS_W;

	logic [CNT_W-1:0] occ_q;
	logic [CMP_W-1:0] occ_ext;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] last;
	logic [CMP_W-1:0] tgt;
	logic             is_ins;
	logic             is_rem;
	logic             is_rd;
	logic             full;
	ids_pkg::status_t status;

	assign occ_ext = CMP_W'(occ_q);
	assign pos_ext = CMP_W'(position);
	assign last    = (occ_q != '0) ? occ_ext - CMP_W'(1) : '0;
	assign full    = (occ_q == CNT_W'(DEPTH));

	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		is_rd  = 1'b0;
		tgt    = '0;
		case (opcode)
			ids_pkg::OP_INS_FRONT: is_ins = 1'b1;
			ids_pkg::OP_INS_BACK: begin
				is_ins = 1'b1;
				tgt    = occ_ext;
			end
			ids_pkg::OP_RD_FRONT: is_rd = 1'b1;
			ids_pkg::OP_RD_BACK: begin
				is_rd = 1'b1;
				tgt   = last;
			end
			ids_pkg::OP_REM_FRONT: is_rem = 1'b1;
			ids_pkg::OP_REM_BACK: begin
				is_rem = 1'b1;
				tgt    = last;
			end
			ids_pkg::OP_RD_POS: begin
				is_rd = 1'b1;
				tgt   = pos_ext;
			end
			ids_pkg::OP_INS_POS: begin
				is_ins = 1'b1;
				tgt    = pos_ext;
			end
			ids_pkg::OP_REM_POS: begin
				is_rem = 1'b1;
				tgt    = pos_ext;
			end
			default: ;
		endcase

		// A full store is reported ahead of a bad insert position.
		if (is_ins) begin
			if (full) begin
				status = ids_pkg::ST_FULL;
			end else if (tgt > occ_ext) begin
				status = ids_pkg::ST_RANGE;
			end else begin
				status = ids_pkg::ST_OK;
			end
		end else if (is_rd || is_rem) begin
			status = (tgt < occ_ext) ? ids_pkg::ST_OK : ids_pkg::ST_RANGE;
		end else begin
			status = ids_pkg::ST_RANGE;
		end
	end

	assign ctl.ins    = is_ins && (status == ids_pkg::ST_OK);
	assign ctl.rem    = is_rem && (status == ids_pkg::ST_OK);
	assign ctl.rd     = (is_rd || is_rem) && (status == ids_pkg::ST_OK);
	assign ctl.status = status;
	assign idx        = tgt[IDX_W-1:0];

	always_comb begin
		count_next = occ_q;
		if (ctl.ins) begin
			count_next = occ_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_next = occ_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (en) begin
			occ_q <= count_next;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy beyond depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl.ins |=> occ_q == $past(occ_q) + CNT_W'(1))
		else $error("successful insert did not grow occupancy");

endmodule

@@ rtl/indexed_deque_store.sv @@
// Ordered store of up to DEPTH words, kept in a row of cells with the front
// in cell 0. Each input beat carries one operation (insert, read or remove
// at the front, the back or a position) and yields exactly one output beat
// with a status, the word read or removed, and the count after the operation.
// Both channels use valid/ready; a beat moves when valid and ready are high.
// Insert and remove shift the whole row by one cell in the accept cycle, so
// every operation takes effect at once and the next beat may follow in the
// very next cycle: one operation per cycle sustained while out_ready is high.
// On the way to the output beat, the cells capture the selected word at
// accept, and the reduction over all cells is registered into the output
// stage once that stage advances.
// When the receiver stalls, the result waits in the output register and one
// more operation may be taken and held in the middle stage; after that
// in_ready drops until out_ready returns.
// Reset empties the store and drops both stages; stored words themselves
// are not cleared, as only words below the count are ever read.
module indexed_deque_store #(
	parameter int DEPTH = ids_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ids_pkg::DATA_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ids_pkg::OPCODE_W-1:0] opcode,
	input  logic [ids_pkg::POS_W-1:0]    position,
	input  logic [ids_pkg::ITEM_W-1:0]   item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ids_pkg::STATUS_W-1:0] status,
	output logic [ids_pkg::ITEM_W-1:0]   result_item,
	output logic [ids_pkg::COUNT_W-1:0]  count
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ids_pkg::op_ctl_t      ctl;
	logic [IDX_W-1:0]      idx;
	logic [CNT_W-1:0]      count_next;
	logic                  accept;
	logic                  advance;
	logic [DATA_WIDTH-1:0] new_item;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_tap [DEPTH];
	logic [DATA_WIDTH-1:0] tap_or;

	logic                         valid_s1;
	ids_pkg::status_t             status_s1;
	logic [CNT_W-1:0]             count_s1;
	logic                         out_valid_q;
	logic [ids_pkg::STATUS_W-1:0] status_q;
	logic [ids_pkg::ITEM_W-1:0]   result_item_q;
	logic [ids_pkg::COUNT_W-1:0]  count_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign new_item = DATA_WIDTH'(item);

	ids_ctrl #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.opcode    (opcode),
		.position  (position),
		.ctl       (ctl),
		.idx       (idx),
		.count_next(count_next)
	);

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;

		if (g == 0) begin : g_first
			assign left = cell_data[g];
		end else begin : g_mid_lo
			assign left = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right = cell_data[g];
		end else begin : g_mid_hi
			assign right = cell_data[g+1];
		end

		ids_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.IDX_W     (IDX_W),
			.CELL_IDX  (g)
		) u_cell (
			.clk     (clk),
			.en      (accept),
			.ctl     (ctl),
			.idx     (idx),
			.new_item(new_item),
			.left    (left),
			.right   (right),
			.data    (cell_data[g]),
			.tap     (cell_tap[g])
		);
	end

	// At most one cell holds a nonzero tap, so an OR picks the selected word.
	always_comb begin
		tap_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= ctl.status;
			count_s1  <= count_next;
		end
		if (advance && valid_s1) begin
			status_q      <= status_s1;
			result_item_q <= ids_pkg::ITEM_W'(tap_or);
			count_q       <= ids_pkg::COUNT_W'(count_s1);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_item = result_item_q;
	assign count       = count_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ids_pkg::ST_OK |-> result_item == '0)
		else $error("nonzero result word on a failed operation");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ids_pkg::ST_FULL |-> count == ids_pkg::COUNT_W'(DEPTH))
		else $error("full status reported below depth");

endmodule

@@ tb/sv/ids_checker.sv @@
module ids_checker
	import ids_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [POS_W-1:0]    position,
	input  logic [ITEM_W-1:0]   item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [STATUS_W-1:0] status,
	input  logic [ITEM_W-1:0]   result_item,
	input  logic [COUNT_W-1:0]  count,
	output int unsigned         fails,
	output int unsigned         pending,
	output int unsigned         stored,
	output int unsigned         peak,
	output int unsigned         ok_ops,
	output int unsigned         range_ops,
	output int unsigned         full_ops
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t            status;
		logic [ITEM_W-1:0]  word;
		logic [COUNT_W-1:0] cnt;
	} result_t;

	// Front of the store is index 0, as in the block's cell row.
	logic [ITEM_W-1:0] shadow_words[$];
	result_t due_results[$];

	function automatic status_t put_word(input int idx, input logic [ITEM_W-1:0] w);
		if (shadow_words.size() >= DEPTH)
			return ST_FULL;
		if (idx > shadow_words.size())
			return ST_RANGE;
		shadow_words.insert(idx, w);
		return ST_OK;
	endfunction

	function automatic void pull_word(input int idx, input bit drop, inout result_t r);
		if (idx >= 0 && idx < shadow_words.size()) begin
			r.status = ST_OK;
			r.word = shadow_words[idx];
			if (drop)
				shadow_words.delete(idx);
		end
	endfunction

	function automatic result_t apply_op(input logic [OPCODE_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [ITEM_W-1:0] w);
		result_t r;
		int n;
		n = shadow_words.size();
		r.status = ST_RANGE;
		r.word = '0;
		case (op)
			OP_INS_FRONT: r.status = put_word(0, w);
			OP_INS_BACK:  r.status = put_word(n, w);
			OP_INS_POS:   r.status = put_word(int'(pos), w);
			OP_RD_FRONT:  pull_word(0, 1'b0, r);
			OP_RD_BACK:   pull_word(n - 1, 1'b0, r);
			OP_RD_POS:    pull_word(int'(pos), 1'b0, r);
			OP_REM_FRONT: pull_word(0, 1'b1, r);
			OP_REM_BACK:  pull_word(n - 1, 1'b1, r);
			OP_REM_POS:   pull_word(int'(pos), 1'b1, r);
			default:      r.status = ST_RANGE;
		endcase
		r.cnt = COUNT_W'(shadow_words.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			shadow_words.delete();
			due_results.delete();
			stored = 0;
			pending = 0;
		end else begin
			if (in_valid && in_ready) begin
				want = apply_op(opcode, position, item);
				due_results.push_back(want);
				case (want.status)
					ST_OK:   ok_ops++;
					ST_FULL: full_ops++;
					default: range_ops++;
				endcase
			end
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result beat with no operation outstanding");
					fails++;
				end else begin
					want = due_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
					if (result_item !== want.word) begin
						$error("result_item: expected %h, got %h",
							want.word, result_item);
						fails++;
					end
					if (count !== want.cnt) begin
						$error("count: expected %0d, got %0d", want.cnt, count);
						fails++;
					end
				end
			end
			stored = shadow_words.size();
			pending = due_results.size();
			if (stored > peak)
				peak = stored;
		end
	end

endmodule

@@ tb/sv/tb_indexed_deque_store.sv @@
module tb_indexed_deque_store;
	import ids_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DEPTH_DEF;
	localparam int TOTAL_ITEMS = 800;
	localparam int HOLD_OFF = 300;
	localparam int STALL_LIMIT = 2000;
	localparam logic [OPCODE_W-1:0] OP_UNDEF_LO = OPCODE_W'(OP_REM_POS + 1);
	localparam logic [OPCODE_W-1:0] OP_UNDEF_HI = '1;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode = OP_RD_FRONT;
	logic [POS_W-1:0]    position = '0;
	logic [ITEM_W-1:0]   item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ITEM_W-1:0]   result_item;
	logic [COUNT_W-1:0]  count;

	int unsigned fails, pending, stored, peak, ok_ops, range_ops, full_ops;
	int unsigned beats_in = 0;
	bit no_idle = 1'b0;

	indexed_deque_store dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.position   (position),
		.item       (item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.result_item(result_item),
		.count      (count)
	);

	ids_checker #(.DEPTH(DEPTH)) deque_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.position   (position),
		.item       (item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.result_item(result_item),
		.count      (count),
		.fails      (fails),
		.pending    (pending),
		.stored     (stored),
		.peak       (peak),
		.ok_ops     (ok_ops),
		.range_ops  (range_ops),
		.full_ops   (full_ops)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Positions mostly land inside the store or one past its end.
	function automatic logic [POS_W-1:0] pick_pos();
		if ($urandom_range(0, 99) < 80)
			return POS_W'($urandom_range(0, stored));
		return POS_W'($urandom_range(0, POS_MAX));
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_insert();
		case ($urandom_range(0, 2))
			0: return OP_INS_FRONT;
			1: return OP_INS_BACK;
			default: return OP_INS_POS;
		endcase
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_drain();
		if ($urandom_range(0, 9) < 2)
			return $urandom_range(0, 1) ? OP_RD_POS : OP_RD_FRONT;
		case ($urandom_range(0, 2))
			0: return OP_REM_FRONT;
			1: return OP_REM_BACK;
			default: return OP_REM_POS;
		endcase
	endfunction

	task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [ITEM_W-1:0] w);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		position <= pos;
		item <= w;
		do @(posedge clk); while (!in_ready);
		beats_in++;
	endtask

	// Fill to the top, then keep pushing so that inserts get refused.
	task automatic fill_round();
		while (stored < DEPTH)
			send_op(pick_insert(), pick_pos(), $urandom());
		send_op(OP_INS_POS, POS_MAX, $urandom());
		repeat ($urandom_range(1, 5))
			send_op(pick_insert(), pick_pos(), $urandom());
	endtask

	task automatic drain_round();
		while (stored > 0)
			send_op(pick_drain(), pick_pos(), $urandom());
		repeat ($urandom_range(2, 4))
			send_op(pick_drain(), pick_pos(), $urandom());
	endtask

	task automatic mixed_round();
		logic [OPCODE_W-1:0] op;
		repeat ($urandom_range(20, 60)) begin
			if ($urandom_range(0, 99) < 8)
				op = OPCODE_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
			else
				op = OPCODE_W'($urandom_range(OP_INS_FRONT, OP_REM_POS));
			send_op(op, pick_pos(), $urandom());
		end
	endtask

	initial begin : receiver
		int unsigned gap;
		bit held_off;
		held_off = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!held_off && beats_in >= 100) begin
				// Long stall on the result side while the sender keeps offering.
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			gap = pick_gap();
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("no beat moved for %0d cycles, %0d results outstanding",
					STALL_LIMIT, pending);
				$display("indexed_deque_store test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every read and remove on an empty store, then a small store
		// exercised at its ends, its middle and past its end.
		send_op(OP_RD_FRONT, '0, '0);
		send_op(OP_RD_BACK, '0, '0);
		send_op(OP_REM_FRONT, '0, '0);
		send_op(OP_REM_BACK, '0, '0);
		send_op(OP_RD_POS, '0, '0);
		send_op(OP_REM_POS, '0, '0);
		send_op(OP_INS_POS, 7'd1, 32'hDEAD_BEEF);
		send_op(OP_INS_POS, '0, 32'h0000_0000);
		send_op(OP_INS_FRONT, '0, 32'hFFFF_FFFF);
		send_op(OP_INS_BACK, '0, 32'hAAAA_AAAA);
		send_op(OP_INS_POS, 7'd3, 32'h5555_5555);
		send_op(OP_INS_POS, 7'd1, 32'h1234_5678);
		send_op(OP_RD_POS, 7'd4, '0);
		send_op(OP_RD_POS, 7'd5, '0);
		send_op(OP_RD_POS, POS_MAX, '1);
		send_op(OP_RD_FRONT, '0, '0);
		send_op(OP_RD_BACK, '0, '0);
		send_op(OP_REM_POS, 7'd2, '0);
		send_op(OP_REM_POS, 7'd64, '0);
		send_op(OP_UNDEF_LO, '0, '0);
		send_op(OP_UNDEF_HI, POS_MAX, '1);
		send_op(OP_REM_FRONT, '0, '0);
		send_op(OP_REM_BACK, '0, '0);
		send_op(OP_INS_POS, POS_MAX, 32'hCAFE_F00D);

		fill_round();
		while (beats_in < TOTAL_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2: fill_round();
				3, 4, 5: drain_round();
				default: mixed_round();
			endcase
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d operations checked: %0d ok, %0d empty or out of range,",
			ok_ops + range_ops + full_ops, ok_ops, range_ops);
		$display("%0d refused as full; store filled to %0d of %0d words at its deepest",
			full_ops, peak, DEPTH);
		if (fails == 0 && pending == 0)
			$display("indexed_deque_store test passed");
		else
			$display("indexed_deque_store test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ids_pkg.sv
rtl/ids_cell.sv
rtl/ids_ctrl.sv
rtl/indexed_deque_store.sv
tb/sv/ids_checker.sv
tb/sv/tb_indexed_deque_store.sv
